FILE: rtl/core/plane_fit_and_point_distance_top_defines.svh
// Assertion macros for the plane fit and point distance block.
`ifndef PLANE_FIT_AND_POINT_DISTANCE_TOP_DEFINES_SVH
`define PLANE_FIT_AND_POINT_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFD_ASSERT_SAME(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("pfd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFD_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("pfd check failed");

`endif

FILE: rtl/core/pfd_pkg.sv
// Shared constants for the plane fit and point distance block.
package pfd_pkg;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned S_TDATA_W  = 9 * COORD_W;
    localparam int unsigned S_TUSER_W  = 1;
    localparam int unsigned M_TDATA_W  = 5 * COORD_W;
    localparam int unsigned M_TUSER_W  = 2;
    localparam logic        OP_FIT     = 1'b0;
    localparam logic        OP_DIST    = 1'b1;
    localparam int unsigned TU_DEGEN   = 0;
    localparam int unsigned TU_SAT     = 1;
endpackage

FILE: rtl/core/plane_fit_and_point_distance_top.sv
// Plane fit from three points and signed point-to-plane distance, top level.
// Input channel (s_*): one transfer carries an opcode in s_tuser and three
// Q16.16 points in s_tdata. Opcode fit builds a unit normal (Q2.30) from the
// cross product of (p2-p1) and (p3-p1), sets offset = -(n . p2) and stores the
// plane. Opcode distance returns (n . p1) + offset in Q16.16.
// Result channel (m_*): exactly one transfer per input transfer, carrying the
// stored plane, the distance and the degenerate / saturated flags.
// Datapath: one item at a time through a single 33x33 multiplier, a bit-serial
// square root and a restoring divider (one division per normal component).
// A fit runs the cross product, sign and normalize (one-bit shifts), sum of
// squares, square root, divisions, dot product and finish, in that order.
// Collinear points go from normalize straight to finish; a distance item
// runs three multiply-accumulates plus rounding. The next item is taken
// once the sequencer is back in idle.
// s_tready is high only while the sequencer is idle; the next item may be
// accepted while the previous result still waits in the output register.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register frees up.
// Reset (aresetn low, synchronous) clears the stored plane to zero and drops
// m_tvalid.
module plane_fit_and_point_distance_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z (lowest bit up)
    input  logic [pfd_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [pfd_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // normal_x, normal_y, normal_z, offset, distance (lowest bit up)
    output logic [pfd_pkg::M_TDATA_W-1:0]   m_tdata,
    // degenerate, saturated (lowest bit up)
    output logic [pfd_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CR_MUL   = 4'd1;
    localparam logic [3:0] ST_CR_ACC   = 4'd2;
    localparam logic [3:0] ST_ABS      = 4'd3;
    localparam logic [3:0] ST_NORM     = 4'd4;
    localparam logic [3:0] ST_SQ_MUL   = 4'd5;
    localparam logic [3:0] ST_SQ_ACC   = 4'd6;
    localparam logic [3:0] ST_SQRT     = 4'd7;
    localparam logic [3:0] ST_DIV_INIT = 4'd8;
    localparam logic [3:0] ST_DIV_STEP = 4'd9;
    localparam logic [3:0] ST_DOT_MUL  = 4'd10;
    localparam logic [3:0] ST_DOT_ACC  = 4'd11;
    localparam logic [3:0] ST_FINISH   = 4'd12;

    localparam logic signed [38:0] I32_MAX = 39'sd2147483647;
    localparam logic signed [38:0] I32_MIN = -39'sd2147483648;

    logic [3:0]          state_reg;
    logic [2:0]          idx_reg;
    logic [4:0]          cnt_reg;
    logic                op_reg;
    logic                degen_reg;

    logic signed [32:0]  u_reg [3];
    logic signed [32:0]  v_reg [3];
    logic signed [31:0]  pt_reg [3];
    logic signed [67:0]  cr_reg [3];
    logic [67:0]         mag_reg [3];
    logic                neg_reg [3];

    logic signed [31:0]  pn_reg [3];
    logic signed [31:0]  poff_reg;

    logic signed [65:0]  prod_reg;
    logic signed [67:0]  acc_reg;

    logic [63:0]         sq_n_reg;
    logic [63:0]         sq_res_reg;
    logic [63:0]         sq_bit_reg;

    logic [31:0]         dv_r_reg;
    logic [30:0]         dq_reg;

    logic                m_valid_reg;
    logic [pfd_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [pfd_pkg::M_TUSER_W-1:0] m_user_reg;

    // shared multiplier operands
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CR_MUL: begin
                unique case (idx_reg)
                    3'd0:    begin mul_a = u_reg[1]; mul_b = v_reg[2]; end
                    3'd1:    begin mul_a = u_reg[2]; mul_b = v_reg[1]; end
                    3'd2:    begin mul_a = u_reg[2]; mul_b = v_reg[0]; end
                    3'd3:    begin mul_a = u_reg[0]; mul_b = v_reg[2]; end
                    3'd4:    begin mul_a = u_reg[0]; mul_b = v_reg[1]; end
                    3'd5:    begin mul_a = u_reg[1]; mul_b = v_reg[0]; end
                    default: begin mul_a = u_reg[0]; mul_b = v_reg[0]; end
                endcase
            end
            ST_SQ_MUL: begin
                mul_a = $signed({2'b00, mag_reg[idx_reg[1:0]][30:0]});
                mul_b = mul_a;
            end
            ST_DOT_MUL: begin
                mul_a = {pn_reg[idx_reg[1:0]][31], pn_reg[idx_reg[1:0]]};
                mul_b = {pt_reg[idx_reg[1:0]][31], pt_reg[idx_reg[1:0]]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic signed [67:0] prod_ext;
    logic signed [67:0] acc_sum;
    logic signed [67:0] acc_diff;
    assign prod_ext = {{2{prod_reg[65]}}, prod_reg};
    assign acc_sum  = acc_reg + prod_ext;
    assign acc_diff = acc_reg - prod_ext;

    // combined magnitude: bit length of the OR equals that of the largest
    logic [67:0] mag_or;
    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

    // square root step
    logic [63:0] sq_t;
    logic        sq_ge;
    assign sq_t  = sq_res_reg + sq_bit_reg;
    assign sq_ge = sq_n_reg >= sq_t;

    // divider
    logic [31:0] sroot;
    logic [61:0] div_num;
    logic [32:0] div_r2;
    logic        div_ge;
    logic [30:0] div_q;
    logic [31:0] div_n;
    assign sroot   = sq_res_reg[31:0];
    assign div_num = {mag_reg[idx_reg[1:0]][30:0], 31'b0} >> 1;
    assign div_r2  = {dv_r_reg, dq_reg[30]};
    assign div_ge  = div_r2 >= {1'b0, sroot};
    assign div_q   = {dq_reg[29:0], div_ge};
    assign div_n   = neg_reg[idx_reg[1:0]] ? (32'd0 - {1'b0, div_q}) : {1'b0, div_q};

    logic [61:0] div_start;
    assign div_start = div_num + {31'b0, sroot[31:1]};

    // rounding of acc to Q16.16 with clamp
    logic [67:0]        acc_mag;
    logic [37:0]        rnd_q;
    logic signed [38:0] rnd_s;
    logic               rnd_sat;
    logic signed [31:0] rnd_v;
    assign acc_mag = acc_reg[67] ? (68'd0 - acc_reg) : acc_reg;
    assign rnd_q   = 38'((acc_mag + 68'(1) * (68'd1 << 29)) >> 30);
    assign rnd_s   = acc_reg[67] ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});

    always_comb begin
        rnd_sat = 1'b0;
        rnd_v   = rnd_s[31:0];
        if (rnd_s > I32_MAX) begin
            rnd_sat = 1'b1;
            rnd_v   = 32'sh7FFF_FFFF;
        end else if (rnd_s < I32_MIN) begin
            rnd_sat = 1'b1;
            rnd_v   = 32'sh8000_0000;
        end
    end

    // final result assembly
    logic signed [31:0] off_next;
    logic signed [31:0] dist_next;
    logic               sat_next;

    always_comb begin
        off_next  = poff_reg;
        dist_next = '0;
        sat_next  = 1'b0;
        if (degen_reg) begin
            off_next = '0;
        end else if (op_reg == pfd_pkg::OP_FIT) begin
            if (rnd_v == 32'sh8000_0000) begin
                off_next = 32'sh7FFF_FFFF;
                sat_next = 1'b1;
            end else begin
                off_next = -rnd_v;
                sat_next = rnd_sat;
            end
        end else begin
            dist_next = rnd_v;
            sat_next  = rnd_sat;
        end
    end

    logic s_fire;
    logic out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            degen_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            pn_reg[0]   <= '0;
            pn_reg[1]   <= '0;
            pn_reg[2]   <= '0;
            poff_reg    <= '0;
        end else begin
            // drain; a result loaded in the finish state takes priority
            if (m_valid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        op_reg    <= s_tuser[0];
                        degen_reg <= 1'b0;
                        idx_reg   <= '0;
                        for (int k = 0; k < 3; k++) begin
                            u_reg[k] <= 33'($signed(s_tdata[(3+k)*32 +: 32]))
                                      - 33'($signed(s_tdata[k*32 +: 32]));
                            v_reg[k] <= 33'($signed(s_tdata[(6+k)*32 +: 32]))
                                      - 33'($signed(s_tdata[k*32 +: 32]));
                        end
                        if (s_tuser[0] == pfd_pkg::OP_FIT) begin
                            for (int k = 0; k < 3; k++) begin
                                pt_reg[k] <= s_tdata[(3+k)*32 +: 32];
                            end
                            state_reg <= ST_CR_MUL;
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                pt_reg[k] <= s_tdata[k*32 +: 32];
                            end
                            acc_reg   <= {{6{poff_reg[31]}}, poff_reg, 30'b0};
                            state_reg <= ST_DOT_MUL;
                        end
                    end
                end
                ST_CR_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_CR_ACC;
                end
                ST_CR_ACC: begin
                    if (!idx_reg[0]) begin
                        acc_reg <= prod_ext;
                    end else begin
                        cr_reg[idx_reg[2:1]] <= acc_diff;
                    end
                    if (idx_reg == 3'd5) begin
                        state_reg <= ST_ABS;
                    end else begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= ST_CR_MUL;
                    end
                end
                ST_ABS: begin
                    for (int k = 0; k < 3; k++) begin
                        neg_reg[k] <= cr_reg[k][67];
                        mag_reg[k] <= cr_reg[k][67] ? (68'd0 - cr_reg[k]) : cr_reg[k];
                    end
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    // one-bit shifts until the largest magnitude is 31 bits long
                    if (mag_or == '0) begin
                        degen_reg <= 1'b1;
                        pn_reg[0] <= '0;
                        pn_reg[1] <= '0;
                        pn_reg[2] <= '0;
                        state_reg <= ST_FINISH;
                    end else if (|mag_or[67:31]) begin
                        for (int k = 0; k < 3; k++) mag_reg[k] <= mag_reg[k] >> 1;
                    end else if (!mag_or[30]) begin
                        for (int k = 0; k < 3; k++) mag_reg[k] <= mag_reg[k] << 1;
                    end else begin
                        acc_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQ_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC: begin
                    acc_reg <= acc_sum;
                    if (idx_reg == 3'd2) begin
                        sq_n_reg   <= acc_sum[63:0];
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'd1 << 62;
                        state_reg  <= ST_SQRT;
                    end else begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQRT: begin
                    if (sq_ge) begin
                        sq_n_reg   <= sq_n_reg - sq_t;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        idx_reg   <= '0;
                        state_reg <= ST_DIV_INIT;
                    end
                end
                ST_DIV_INIT: begin
                    dv_r_reg  <= {1'b0, div_start[61:31]};
                    dq_reg    <= div_start[30:0];
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV_STEP;
                end
                ST_DIV_STEP: begin
                    dv_r_reg <= div_ge ? 32'(div_r2 - {1'b0, sroot}) : div_r2[31:0];
                    dq_reg   <= div_q;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd30) begin
                        pn_reg[idx_reg[1:0]] <= div_n;
                        if (idx_reg == 3'd2) begin
                            acc_reg   <= '0;
                            idx_reg   <= '0;
                            state_reg <= ST_DOT_MUL;
                        end else begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= ST_DIV_INIT;
                        end
                    end
                end
                ST_DOT_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_DOT_ACC;
                end
                ST_DOT_ACC: begin
                    acc_reg <= acc_sum;
                    if (idx_reg == 3'd2) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= ST_DOT_MUL;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        poff_reg    <= off_next;
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {dist_next, off_next, pn_reg[2], pn_reg[1], pn_reg[0]};
                        m_user_reg  <= {sat_next, degen_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/core/pfd_checker.sv
// Port-level checks for the plane fit and point distance block, with bind.
`include "plane_fit_and_point_distance_top_defines.svh"

module pfd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pfd_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [pfd_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pfd_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [pfd_pkg::M_TUSER_W-1:0]   m_tuser
);

    // one item in flight: no back-to-back input transfers
    `PFD_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // stalled result holds
    `PFD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // degenerate fit: all-zero plane, zero distance, no saturation
    `PFD_ASSERT_SAME(a_degen_zero, m_tvalid && m_tuser[pfd_pkg::TU_DEGEN],
        m_tdata == '0 && !m_tuser[pfd_pkg::TU_SAT])

endmodule

bind plane_fit_and_point_distance_top pfd_checker u_pfd_checker (.*);
